/* hdl/qefs_pkg.sv */
// shared types, constants and helpers for the quoted escaped field splitter
package qefs_pkg;

	// capacity of each character set
	localparam int MAX_DELIMS  = 4;
	localparam int MAX_QUOTES  = 2;
	localparam int MAX_ESCAPES = 2;

	// usable entries: capacity limited by the bytes each register holds
	localparam int DELIM_LIM = (MAX_DELIMS < 4) ? MAX_DELIMS : 4;
	localparam int QUOTE_LIM = (MAX_QUOTES < 2) ? MAX_QUOTES : 2;
	localparam int ESC_LIM   = (MAX_ESCAPES < 2) ? MAX_ESCAPES : 2;

	// result queue
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// register indexes
	localparam logic [2:0] REG_SPLIT_MODE   = 3'd0;
	localparam logic [2:0] REG_DROP_EMPTY   = 3'd1;
	localparam logic [2:0] REG_DELIM_SET    = 3'd2;
	localparam logic [2:0] REG_DELIM_COUNT  = 3'd3;
	localparam logic [2:0] REG_QUOTE_SET    = 3'd4;
	localparam logic [2:0] REG_QUOTE_COUNT  = 3'd5;
	localparam logic [2:0] REG_ESCAPE_SET   = 3'd6;
	localparam logic [2:0] REG_ESCAPE_COUNT = 3'd7;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_ESC_END = 2'd1;
	localparam logic [1:0] ERR_BAD_ESC = 2'd2;

	// special characters
	localparam logic [7:0] CHAR_N  = 8'h6E;
	localparam logic [7:0] CHAR_NL = 8'h0A;

	typedef struct packed {
		logic [7:0] in_char;
		logic       line_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       token_end;
		logic       line_end;
		logic [1:0] error_code;
	} out_beat_t;

	typedef struct packed {
		logic        split_mode;
		logic        drop_empty;
		logic [31:0] delim_set;
		logic [2:0]  delim_count;
		logic [15:0] quote_set;
		logic [1:0]  quote_count;
		logic [15:0] escape_set;
		logic [1:0]  escape_count;
	} cfg_t;

	// results produced by one byte, handed to the queue
	typedef struct packed {
		logic [1:0]      cnt;
		out_beat_t [1:0] res;
	} push_t;

	// match a byte against the first num bytes of a packed set
	function automatic logic match_set(input logic [31:0] set, input logic [2:0] num,
		input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if ((3'(i) < num) && (set[8*i +: 8] == c)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

/* hdl/qefs_cfg.sv */
// configuration registers of the splitter
module qefs_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output qefs_pkg::cfg_t cfg
);
	import qefs_pkg::*;

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.split_mode   <= 1'b0;
			cfg_q.drop_empty   <= 1'b0;
			cfg_q.delim_set    <= 32'd44;
			cfg_q.delim_count  <= 3'd1;
			cfg_q.quote_set    <= 16'd34;
			cfg_q.quote_count  <= 2'd1;
			cfg_q.escape_set   <= 16'd92;
			cfg_q.escape_count <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPLIT_MODE:   cfg_q.split_mode   <= cfg_data[0];
				REG_DROP_EMPTY:   cfg_q.drop_empty   <= cfg_data[0];
				REG_DELIM_SET:    cfg_q.delim_set    <= cfg_data;
				REG_DELIM_COUNT:  cfg_q.delim_count  <= cfg_data[2:0];
				REG_QUOTE_SET:    cfg_q.quote_set    <= cfg_data[15:0];
				REG_QUOTE_COUNT:  cfg_q.quote_count  <= cfg_data[1:0];
				REG_ESCAPE_SET:   cfg_q.escape_set   <= cfg_data[15:0];
				REG_ESCAPE_COUNT: cfg_q.escape_count <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/qefs_decode.sv */
// per-byte classification, tokenizer state and result generation
module qefs_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  qefs_pkg::cfg_t    cfg,
	input  qefs_pkg::in_beat_t item_s1,
	input  logic              fire,
	output qefs_pkg::push_t   push
);
	import qefs_pkg::*;

	logic       in_quote_q, esc_pend_q, tok_bytes_q;
	logic [1:0] err_held_q;
	logic       in_quote_d, esc_pend_d, tok_bytes_d;
	logic [1:0] err_held_d;

	logic [2:0] delim_num, quote_num, esc_num;
	logic       is_d, is_q, is_e, last, close_a, close_b;
	logic [7:0] ch;
	out_beat_t  blank, tok, dat, r0, r1;
	logic [1:0] n;

	// clamp counts to usable capacity
	always_comb begin
		delim_num = (cfg.delim_count > 3'(DELIM_LIM)) ? 3'(DELIM_LIM) : cfg.delim_count;
		quote_num = ({1'b0, cfg.quote_count} > 3'(QUOTE_LIM)) ? 3'(QUOTE_LIM)
			: {1'b0, cfg.quote_count};
		esc_num = ({1'b0, cfg.escape_count} > 3'(ESC_LIM)) ? 3'(ESC_LIM)
			: {1'b0, cfg.escape_count};
	end

	// set compares
	assign ch   = item_s1.in_char;
	assign last = item_s1.line_last;
	assign is_d = match_set(cfg.delim_set, delim_num, ch);
	assign is_q = match_set({16'd0, cfg.quote_set}, quote_num, ch);
	assign is_e = match_set({16'd0, cfg.escape_set}, esc_num, ch);

	// result templates
	always_comb begin
		blank = '0;
		tok = '0;
		tok.token_end = 1'b1;
		dat = '0;
		dat.out_char = ch;
		dat.char_valid = 1'b1;
		dat.token_end = last;
	end

	// byte decision and next state
	always_comb begin
		in_quote_d  = in_quote_q;
		esc_pend_d  = esc_pend_q;
		tok_bytes_d = tok_bytes_q;
		err_held_d  = err_held_q;
		r0 = blank;
		r1 = blank;
		n  = 2'd0;
		close_a = tok_bytes_q || !cfg.drop_empty;
		close_b = last && !cfg.drop_empty;
		if (err_held_q != ERR_NONE) begin
			// rest of line dropped, error reported with its final byte
			if (last) begin
				r0.error_code = err_held_q;
				n = 2'd1;
			end
		end else if (!cfg.split_mode) begin
			in_quote_d = 1'b0;
			esc_pend_d = 1'b0;
			if (is_d) begin
				r0 = tok;
				r1 = tok;
				n = 2'({1'b0, close_a}) + 2'({1'b0, close_b});
				tok_bytes_d = 1'b0;
			end else begin
				r0 = dat;
				n = 2'd1;
				tok_bytes_d = 1'b1;
			end
		end else if (esc_pend_q) begin
			esc_pend_d = 1'b0;
			if (ch == CHAR_N) begin
				r0 = dat;
				r0.out_char = CHAR_NL;
				n = 2'd1;
				tok_bytes_d = 1'b1;
			end else if (!(is_q || is_d || is_e)) begin
				r0.error_code = ERR_BAD_ESC;
				n = 2'd1;
				tok_bytes_d = 1'b0;
				in_quote_d = 1'b0;
				err_held_d = ERR_BAD_ESC;
			end else begin
				r0 = dat;
				n = 2'd1;
				tok_bytes_d = 1'b1;
			end
		end else if (is_e) begin
			if (last) begin
				r0.error_code = ERR_ESC_END;
				n = 2'd1;
			end else begin
				esc_pend_d = 1'b1;
			end
		end else if (is_d && !in_quote_q) begin
			if (close_a) begin
				r0 = tok;
				n = 2'd1;
			end
			tok_bytes_d = 1'b0;
		end else if (is_d || !is_q) begin
			r0 = dat;
			n = 2'd1;
			tok_bytes_d = 1'b1;
		end else begin
			// quote toggles and is dropped
			in_quote_d = !in_quote_q;
			if (last) begin
				if (close_a) begin
					r0 = tok;
					n = 2'd1;
				end
				tok_bytes_d = 1'b0;
			end
		end
		// end of line: mark last result and clear state
		if (last) begin
			if (n == 2'd0) begin
				n = 2'd1;
				r0 = blank;
			end
			if (n == 2'd1) begin
				r0.line_end = 1'b1;
			end else begin
				r1.line_end = 1'b1;
			end
			in_quote_d  = 1'b0;
			esc_pend_d  = 1'b0;
			tok_bytes_d = 1'b0;
			err_held_d  = ERR_NONE;
		end
	end

	// tokenizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q  <= 1'b0;
			esc_pend_q  <= 1'b0;
			tok_bytes_q <= 1'b0;
			err_held_q  <= ERR_NONE;
		end else if (fire) begin
			in_quote_q  <= in_quote_d;
			esc_pend_q  <= esc_pend_d;
			tok_bytes_q <= tok_bytes_d;
			err_held_q  <= err_held_d;
		end
	end

	assign push = '{cnt: fire ? n : 2'd0, res: {r1, r0}};

	// state is clean after a line's final byte
	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.line_last |=> !in_quote_q && !esc_pend_q && !tok_bytes_q
			&& (err_held_q == ERR_NONE))
		else $error("state not cleared after line end");

	// a byte never yields more than two results
	a_push_max: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd3)
		else $error("too many results for one byte");

endmodule

/* hdl/qefs_resq.sv */
// result queue: takes up to two results a cycle while it has room, hands out one beat a cycle while result_stall is low
module qefs_resq (
	input  logic                clk,
	input  logic                arst_n,
	input  qefs_pkg::push_t     push,
	output logic                room,
	output logic                result_valid,
	input  logic                result_stall,
	output qefs_pkg::out_beat_t result
);
	import qefs_pkg::*;

	out_beat_t          mem_q [Q_DEPTH];
	logic [QPTR_W-1:0]  head_q, tail_q;
	logic [QCNT_W-1:0]  count_q;
	logic               pop;

	assign result_valid = (count_q != '0);
	assign pop          = result_valid && !result_stall;
	assign room         = (count_q <= QCNT_W'(Q_DEPTH - 2));
	assign result       = mem_q[head_q];

	// storage writes
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[tail_q] <= push.res[0];
		end
		if (push.cnt == 2'd2) begin
			mem_q[tail_q + QPTR_W'(1)] <= push.res[1];
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + QPTR_W'(1);
			end
			tail_q  <= tail_q + QPTR_W'(push.cnt);
			count_q <= count_q + QCNT_W'(push.cnt) - QCNT_W'(pop);
		end
	end

	// writes only land when two slots are free
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("result queue written without room");

	// fill level never exceeds depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(Q_DEPTH))
		else $error("result queue overflow");

endmodule

/* hdl/quoted_escaped_field_splitter.sv */
// top level of the quoted escaped field splitter
// a byte waits in the input register, then is decoded into the result queue
// one byte per cycle while the queue has room; two results take two output beats
// the four-entry result queue lets input continue while output is stalled
// reset: configuration to defaults, tokenizer state cleared, queue emptied
module quoted_escaped_field_splitter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                item_valid,
	output logic                item_stall,
	input  qefs_pkg::in_beat_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output qefs_pkg::out_beat_t result
);
	import qefs_pkg::*;

	cfg_t     cfg;
	in_beat_t item_s1;
	logic     vld_s1, room, fire, accept;
	push_t    push;

	assign fire       = vld_s1 && room;
	assign item_stall = vld_s1 && !room;
	assign accept     = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	qefs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qefs_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item_s1 (item_s1),
		.fire    (fire),
		.push    (push)
	);

	qefs_resq u_resq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// a held byte is processed as soon as the queue has room
	a_no_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && room |=> !vld_s1 || $past(accept))
		else $error("input stage held with room available");

endmodule
